/* hdl/shp_pkg.sv */
`timescale 1ns / 1ps
package shp_pkg;

  localparam int MaxNulStringDefault = 512;
  localparam int QueueDepth = 4;

  typedef enum logic [2:0] {
    KIND_REPLY   = 3'd0,
    KIND_DOMAIN  = 3'd1,
    KIND_CONNECT = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_PAYLOAD = 3'd4
  } kind_t;

  // Burst of results that one client byte causes.
  typedef enum logic [2:0] {
    BURST_NONE      = 3'd0,
    BURST_S4_OK     = 3'd1,
    BURST_S4_FAIL   = 3'd2,
    BURST_CLOSE     = 3'd3,
    BURST_S5_METHOD = 3'd4,
    BURST_S5_OK     = 3'd5,
    BURST_SINGLE    = 3'd6
  } burst_t;

  typedef struct packed {
    burst_t      burst;
    logic        lead;       // a domain byte comes before the burst
    logic [2:0]  kind;       // kind of the lead or single result
    logic [7:0]  data;
    logic [1:0]  addr_type;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } cmd_t;

endpackage

/* hdl/shp_front.sv */
`timescale 1ns / 1ps
module shp_front #(
  parameter int MaxNulString = shp_pkg::MaxNulStringDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [7:0]    rx_byte,
  input  logic          conn_start,
  output logic          cmd_valid,
  input  logic          cmd_full,
  output shp_pkg::cmd_t cmd
);
  import shp_pkg::*;

  typedef enum logic [4:0] {
    PH_VER, PH_VER_BAD, PH_S4_CMD, PH_S4_PORT, PH_S4_IP, PH_S4_USER, PH_S4_DOMAIN,
    PH_S5_NMETH, PH_S5_METH, PH_S5_HEAD, PH_S5_IPV4, PH_S5_DLEN, PH_S5_DOMAIN,
    PH_S5_IPV6, PH_S5_PORT, PH_RELAY, PH_CLOSED
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [9:0]  byte_counter, byte_counter_next, bc;
  logic [7:0]  remaining_len, remaining_len_next, rl;
  logic [15:0] port_reg, port_reg_next, pr;
  logic [63:0] addr0, addr0_next, a0;
  logic [63:0] addr1, addr1_next, a1;
  logic [1:0]  address_kind, address_kind_next, ak;
  logic        domain_nonempty, domain_nonempty_next, dn;
  logic [9:0]  bc_inc;
  logic        nul_end;
  logic        accept;
  cmd_t        c;

  assign stall = cmd_full;
  assign accept = valid && !cmd_full;

  always_comb begin
    if (conn_start) begin
      ph = PH_VER; bc = '0; rl = '0; pr = '0; a0 = '0; a1 = '0; ak = '0; dn = 1'b0;
    end else begin
      ph = phase; bc = byte_counter; rl = remaining_len; pr = port_reg;
      a0 = addr0; a1 = addr1; ak = address_kind; dn = domain_nonempty;
    end
  end

  assign bc_inc = bc + 10'd1;
  assign nul_end = (rx_byte == 8'h00) || (bc_inc >= 10'(MaxNulString));

  always_comb begin
    phase_next = ph; byte_counter_next = bc; remaining_len_next = rl;
    port_reg_next = pr; addr0_next = a0; addr1_next = a1;
    address_kind_next = ak; domain_nonempty_next = dn;
    c = '0;
    c.burst = BURST_NONE;
    unique case (ph)
      PH_VER: begin
        byte_counter_next = '0;
        if (rx_byte == 8'h04) phase_next = PH_S4_CMD;
        else if (rx_byte == 8'h05) phase_next = PH_S5_NMETH;
        else phase_next = PH_VER_BAD;
      end
      PH_VER_BAD: begin
        c.burst = BURST_CLOSE; phase_next = PH_CLOSED;
      end
      PH_S4_CMD: begin
        if (rx_byte != 8'h01) begin
          c.burst = BURST_S4_FAIL; phase_next = PH_CLOSED;
        end else begin
          phase_next = PH_S4_PORT; byte_counter_next = '0; port_reg_next = '0;
        end
      end
      PH_S4_PORT: begin
        port_reg_next = {pr[7:0], rx_byte};
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd2) begin
          phase_next = PH_S4_IP; byte_counter_next = '0; addr0_next = '0;
        end
      end
      PH_S4_IP, PH_S5_IPV4: begin
        addr0_next = {32'd0, a0[23:0], rx_byte};
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd4) begin
          phase_next = (ph == PH_S4_IP) ? PH_S4_USER : PH_S5_PORT;
          byte_counter_next = '0;
        end
      end
      PH_S4_USER: begin
        byte_counter_next = bc_inc;
        if (nul_end) begin
          byte_counter_next = '0;
          if (a0[31:8] == 24'd0 && a0[7:0] != 8'd0) begin
            address_kind_next = 2'd1; domain_nonempty_next = 1'b0;
            phase_next = PH_S4_DOMAIN;
          end else begin
            address_kind_next = 2'd0; c.burst = BURST_S4_OK; phase_next = PH_RELAY;
          end
        end
      end
      PH_S4_DOMAIN: begin
        if (rx_byte != 8'h00) begin
          domain_nonempty_next = 1'b1;
          c.lead = 1'b1; c.kind = KIND_DOMAIN; c.data = rx_byte;
        end
        byte_counter_next = bc_inc;
        if (nul_end) begin
          byte_counter_next = '0;
          if (domain_nonempty_next) begin
            c.burst = BURST_S4_OK; phase_next = PH_RELAY;
          end else begin
            c.burst = BURST_S4_FAIL; phase_next = PH_CLOSED;
          end
        end
      end
      PH_S5_NMETH: begin
        remaining_len_next = rx_byte;
        if (rx_byte == 8'h00) begin
          c.burst = BURST_S5_METHOD; phase_next = PH_S5_HEAD; byte_counter_next = '0;
        end else phase_next = PH_S5_METH;
      end
      PH_S5_METH: begin
        remaining_len_next = rl - 8'd1;
        if (remaining_len_next == 8'd0) begin
          c.burst = BURST_S5_METHOD; phase_next = PH_S5_HEAD; byte_counter_next = '0;
        end
      end
      PH_S5_HEAD: begin
        if (bc < 10'd2) port_reg_next = {pr[7:0], rx_byte};
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd4) begin
          byte_counter_next = '0; addr0_next = '0; addr1_next = '0;
          if (port_reg_next != 16'h0501) begin
            c.burst = BURST_CLOSE; phase_next = PH_CLOSED;
          end else if (rx_byte == 8'h01) begin
            address_kind_next = 2'd0; phase_next = PH_S5_IPV4;
          end else if (rx_byte == 8'h03) begin
            address_kind_next = 2'd1; phase_next = PH_S5_DLEN;
          end else if (rx_byte == 8'h04) begin
            address_kind_next = 2'd2; phase_next = PH_S5_IPV6;
          end else begin
            c.burst = BURST_CLOSE; phase_next = PH_CLOSED;
          end
          port_reg_next = '0;
        end
      end
      PH_S5_DLEN: begin
        remaining_len_next = rx_byte;
        domain_nonempty_next = rx_byte != 8'h00;
        phase_next = (rx_byte != 8'h00) ? PH_S5_DOMAIN : PH_S5_PORT;
        byte_counter_next = '0;
      end
      PH_S5_DOMAIN: begin
        c.burst = BURST_SINGLE; c.kind = KIND_DOMAIN; c.data = rx_byte;
        remaining_len_next = rl - 8'd1;
        if (remaining_len_next == 8'd0) begin
          phase_next = PH_S5_PORT; byte_counter_next = '0;
        end
      end
      PH_S5_IPV6: begin
        if (bc < 10'd8) addr1_next = {a1[55:0], rx_byte};
        else addr0_next = {a0[55:0], rx_byte};
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd16) begin
          phase_next = PH_S5_PORT; byte_counter_next = '0;
        end
      end
      PH_S5_PORT: begin
        port_reg_next = {pr[7:0], rx_byte};
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd2) begin
          byte_counter_next = '0; c.burst = BURST_S5_OK; phase_next = PH_RELAY;
        end
      end
      PH_RELAY: begin
        c.burst = BURST_SINGLE; c.kind = KIND_PAYLOAD; c.data = rx_byte;
      end
      PH_CLOSED: ;
      default: phase_next = PH_CLOSED;
    endcase
    // The connect event carries the address as it stands after this byte.
    c.addr_type = address_kind_next;
    c.port = port_reg_next;
    if (address_kind_next == 2'd0) c.addr_low = {32'd0, addr0_next[31:0]};
    else if (address_kind_next == 2'd2) begin
      c.addr_high = addr1_next; c.addr_low = addr0_next;
    end
  end

  assign cmd = c;
  assign cmd_valid = accept && (c.burst != BURST_NONE || c.lead);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_VER; byte_counter <= '0; remaining_len <= '0; port_reg <= '0;
      addr0 <= '0; addr1 <= '0; address_kind <= '0; domain_nonempty <= 1'b0;
    end else if (accept) begin
      phase <= phase_next; byte_counter <= byte_counter_next;
      remaining_len <= remaining_len_next; port_reg <= port_reg_next;
      addr0 <= addr0_next; addr1 <= addr1_next;
      address_kind <= address_kind_next; domain_nonempty <= domain_nonempty_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    cmd_full |-> !accept) else $error("front accepted a request into a full queue");
  a_relay_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(accept) && !$past(conn_start) && $past(phase) == PH_RELAY) |-> phase == PH_RELAY)
    else $error("relay phase left without a new connection");
  a_ipv4_high_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && c.burst == BURST_S4_OK) |-> c.addr_high == 64'd0)
    else $error("SOCKS4 connect with upper address bits");
`endif
endmodule

/* hdl/shp_queue.sv */
`timescale 1ns / 1ps
module shp_queue #(
  parameter int Depth = shp_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  shp_pkg::cmd_t wr_data,
  output logic          full,
  output logic          rd_valid,
  input  logic          rd_en,
  output shp_pkg::cmd_t rd_data
);
  import shp_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0]   count;

  assign full = count == (Aw+1)'(Depth);
  assign rd_valid = count != '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr_en) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> rd_valid)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Aw+1)'(Depth)) else $error("queue count out of range");
`endif
endmodule

/* hdl/shp_back.sv */
`timescale 1ns / 1ps
module shp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  shp_pkg::cmd_t cmd,
  output logic          valid,
  input  logic          stall,
  output logic [2:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic [1:0]    addr_type,
  output logic [15:0]   dest_port,
  output logic [63:0]   addr_high,
  output logic [63:0]   addr_low,
  output logic          last
);
  import shp_pkg::*;

  logic [3:0] idx, idx_next;
  logic [3:0] len;
  logic [3:0] pos;
  logic       step;
  logic [2:0] k;
  logic [7:0] d;
  logic       conn;

  // Result count of a request: optional lead domain byte plus the burst.
  always_comb begin
    case (cmd.burst)
      BURST_S4_OK, BURST_S4_FAIL: len = 4'd9;
      BURST_CLOSE, BURST_SINGLE:  len = 4'd1;
      BURST_S5_METHOD:            len = 4'd2;
      BURST_S5_OK:                len = 4'd11;
      default:                    len = 4'd0;
    endcase
    if (cmd.lead) len = len + 4'd1;
  end

  assign pos = cmd.lead ? idx - 4'd1 : idx;

  always_comb begin
    k = KIND_REPLY; d = 8'd0; conn = 1'b0;
    if (cmd.lead && idx == 4'd0) begin
      k = cmd.kind; d = cmd.data;
    end else begin
      case (cmd.burst)
        BURST_S4_OK, BURST_S4_FAIL: begin
          if (pos == 4'd8) begin
            if (cmd.burst == BURST_S4_OK) begin
              k = KIND_CONNECT; conn = 1'b1;
            end else k = KIND_CLOSE;
          end else if (pos == 4'd1) d = (cmd.burst == BURST_S4_OK) ? 8'h5A : 8'h5B;
        end
        BURST_CLOSE: k = KIND_CLOSE;
        BURST_S5_METHOD: d = (pos == 4'd0) ? 8'h05 : 8'h00;
        BURST_S5_OK: begin
          if (pos == 4'd10) begin
            k = KIND_CONNECT; conn = 1'b1;
          end else if (pos == 4'd0) d = 8'h05;
          else if (pos == 4'd3) d = 8'h01;
        end
        BURST_SINGLE: begin
          k = cmd.kind; d = cmd.data;
        end
        default: ;
      endcase
    end
  end

  assign step = cmd_valid && (!valid || !stall);
  assign idx_next = idx + 4'd1;
  assign cmd_take = step && (idx_next == len);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0; idx <= '0;
    end else begin
      if (step) begin
        valid <= 1'b1;
        idx <= cmd_take ? 4'd0 : idx_next;
      end else if (!stall) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_kind <= k; out_byte <= d;
      addr_type <= conn ? cmd.addr_type : 2'd0;
      dest_port <= conn ? cmd.port : 16'd0;
      addr_high <= conn ? cmd.addr_high : 64'd0;
      addr_low <= conn ? cmd.addr_low : 64'd0;
      last <= idx_next == len;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> (valid && $stable(out_kind) && $stable(last)))
    else $error("result changed while stalled");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> idx < len) else $error("burst index past its length");
  a_connect_last: assert property (@(posedge clk) disable iff (rst)
    (valid && out_kind == KIND_CONNECT) |-> last) else $error("connect not last");
`endif
endmodule

/* hdl/socks_handshake_parser_core.sv */
`timescale 1ns / 1ps
// Server-side SOCKS4/4a/5 connect handshake parser. One client byte is taken per
// cycle; the front parser never waits on the reply path except when its four-entry
// request queue is full. Each byte yields up to eleven results, which the back end
// emits one per cycle while out_stall is low, and a long reply burst (nine for
// SOCKS4, eleven for SOCKS5) makes the input stall once the queue has filled.
// Bytes causing no result put nothing in the queue.
module socks_handshake_parser_core #(
  parameter int MaxNulString = shp_pkg::MaxNulStringDefault,
  parameter int QueueDepth   = shp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        conn_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  addr_type,
  output logic [15:0] dest_port,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low,
  output logic        last
);
  import shp_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, q_full, q_valid, q_take;

  shp_front #(.MaxNulString(MaxNulString)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .rx_byte, .conn_start,
    .cmd_valid(f_valid), .cmd_full(q_full), .cmd(f_cmd)
  );

  shp_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_en(f_valid), .wr_data(f_cmd), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_cmd)
  );

  shp_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .valid(out_valid), .stall(out_stall), .out_kind, .out_byte, .addr_type,
    .dest_port, .addr_high, .addr_low, .last
  );

endmodule
